/* sv/binary_morphology_filter_core_defines.svh */
// Assertion macros for the morphology filter RTL.
`ifndef BINARY_MORPHOLOGY_FILTER_CORE_DEFINES_SVH
`define BINARY_MORPHOLOGY_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bmf_pkg.sv */
// Shared constants, register codes and types of the morphology filter.
package bmf_pkg;

  localparam int MAX_K_DEF      = 5;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int ROW_LIMIT      = 4096;
  localparam int IMG_ROWS_W     = 13;
  localparam int ROW_CNT_W      = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int ELEM_IDX_LIMIT = 64;

  localparam int MODE_RST       = 0;
  localparam int STREL_MASK_RST = 1;
  localparam int STREL_ROWS_RST = 3;
  localparam int STREL_COLS_RST = 3;
  localparam int IMG_ROWS_RST   = 64;
  localparam int IMG_COLS_RST   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_STREL_MASK = 3'd1,
    CFG_STREL_ROWS = 3'd2,
    CFG_STREL_COLS = 3'd3,
    CFG_IMG_ROWS   = 3'd4,
    CFG_IMG_COLS   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } morph_mode_t;

  // Control from the pipeline to the window stage.
  typedef struct packed {
    logic        adv;
    morph_mode_t mode;
  } bmf_ctrl_t;

endpackage

/* sv/bmf_if.sv */
// Valid/ready stream interfaces for input pixels and result pixels.
interface bmf_in_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface bmf_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic row_end;
  logic frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input pixel_out, input row_end, input frame_end,
                output ready);
endinterface

/* sv/bmf_window.sv */
// Window register and erosion / dilation reduction of the morphology filter.
module bmf_window #(
  parameter int MAX_K = bmf_pkg::MAX_K_DEF,
  localparam int LINES  = MAX_K - 1,
  localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1,
  localparam int MASK_W = MAX_K * MAX_K
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bmf_pkg::bmf_ctrl_t ctrl,
  input  logic              pixel,
  input  logic [LINES-1:0]  line_bits,
  input  logic [SLOT_W-1:0] slot,
  input  logic [MASK_W-1:0] ero_mask,
  input  logic [MASK_W-1:0] dil_mask,
  output logic              result
);
  import bmf_pkg::*;

  logic [MAX_K-1:0]  win_r   [MAX_K];
  logic [MAX_K-1:0]  win_nxt [MAX_K];
  logic [MAX_K-1:0]  col;
  logic [MASK_W-1:0] win_flat;

  // Pick the pixel d rows above from the rotating line slots.
  always_comb begin
    int src;
    src = 0;
    col[0] = pixel;
    for (int d = 1; d < MAX_K; d++) begin
      src = int'(slot) + LINES - d;
      if (src >= LINES) begin
        src = src - LINES;
      end
      col[d] = line_bits[src[SLOT_W-1:0]];
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_K; d++) begin
      win_nxt[d] = {win_r[d][MAX_K-2:0], col[d]};
      for (int j = 0; j < MAX_K; j++) begin
        win_flat[d*MAX_K + j] = win_nxt[d][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < MAX_K; d++) begin
        win_r[d] <= '0;
      end
    end else if (ctrl.adv) begin
      win_r <= win_nxt;
    end
  end

  // Erosion: all masked taps set (empty mask gives 1). Dilation: any masked tap set.
  assign result = (ctrl.mode == MODE_DILATE) ? (|(dil_mask & win_flat))
                                             : (&(~ero_mask | win_flat));

endmodule

/* sv/binary_morphology_filter_core.sv */
// Top level of the binary erosion / dilation filter over a raster pixel stream.
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+------------------------
//   in_if    | in  | pixel_in                         | valid & ready
//   out_if   | out | pixel_out, row_end, frame_end    | valid & ready
//   cfg_*    | in  | cfg_index, cfg_data              | cfg_we, no back-pressure
//
// One item per clock sustained while the output is not stalled. An item runs
// through two register stages: the window stage, loaded at acceptance together
// with the registered line store read, and the output register fed by the
// window/reduction logic. Synchronous active-low reset clears counters, window
// and valid flags; the line store is not cleared. A stalled output holds its
// item, the window stage holds one more item with a result, and then the input
// stalls; items without a result pass regardless.
module binary_morphology_filter_core #(
  parameter int MAX_K    = bmf_pkg::MAX_K_DEF,
  parameter int MAX_COLS = bmf_pkg::MAX_COLS_DEF,
  localparam int MASK_W  = MAX_K * MAX_K,
  localparam int NC_W    = $clog2(MAX_COLS + 1),
  localparam int CFG_W   = (MASK_W > bmf_pkg::IMG_ROWS_W)
                           ? ((MASK_W > NC_W) ? MASK_W : NC_W)
                           : ((bmf_pkg::IMG_ROWS_W > NC_W) ? bmf_pkg::IMG_ROWS_W : NC_W)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bmf_in_if.sink                         in_if,
  bmf_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);
  import bmf_pkg::*;

  `include "binary_morphology_filter_core_defines.svh"

  localparam int LINES  = MAX_K - 1;
  localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int K_W    = $clog2(MAX_K + 1);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int IDX_W  = $clog2(MASK_W);

  // ---------------------------------------------------------------- config
  morph_mode_t          mode_r;
  logic [MASK_W-1:0]    strel_mask_r;
  logic [K_W-1:0]       strel_rows_r;
  logic [K_W-1:0]       strel_cols_r;
  logic [IMG_ROWS_W-1:0] img_rows_r;
  logic [NC_W-1:0]      img_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= morph_mode_t'(MODE_RST[0]);
      strel_mask_r <= MASK_W'(STREL_MASK_RST);
      strel_rows_r <= K_W'(STREL_ROWS_RST);
      strel_cols_r <= K_W'(STREL_COLS_RST);
      img_rows_r   <= IMG_ROWS_W'(IMG_ROWS_RST);
      img_cols_r   <= NC_W'(IMG_COLS_RST);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MODE:       mode_r       <= morph_mode_t'(cfg_data[0]);
        CFG_STREL_MASK: strel_mask_r <= cfg_data[MASK_W-1:0];
        CFG_STREL_ROWS: strel_rows_r <= cfg_data[K_W-1:0];
        CFG_STREL_COLS: strel_cols_r <= cfg_data[K_W-1:0];
        CFG_IMG_ROWS:   img_rows_r   <= cfg_data[IMG_ROWS_W-1:0];
        CFG_IMG_COLS:   img_cols_r   <= cfg_data[NC_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Clamp element and image extents into their legal ranges.
  logic [K_W-1:0]        kr, kc;
  logic [IMG_ROWS_W-1:0] nr;
  logic [NC_W-1:0]       nc;

  always_comb begin
    kr = (strel_rows_r == '0) ? K_W'(1)
       : ((int'(strel_rows_r) > MAX_K) ? K_W'(MAX_K) : strel_rows_r);
    kc = (strel_cols_r == '0) ? K_W'(1)
       : ((int'(strel_cols_r) > MAX_K) ? K_W'(MAX_K) : strel_cols_r);
    nr = (img_rows_r == '0) ? IMG_ROWS_W'(1)
       : ((int'(img_rows_r) > ROW_LIMIT) ? IMG_ROWS_W'(ROW_LIMIT) : img_rows_r);
    nc = (img_cols_r == '0) ? NC_W'(1)
       : ((int'(img_cols_r) > MAX_COLS) ? NC_W'(MAX_COLS) : img_cols_r);
  end

  // Tap masks laid out on the window (row d above, column j back). Erosion
  // uses the reflected element, dilation the element as written. They only
  // change with configuration, so register them off the pixel path.
  logic [MASK_W-1:0] ero_mask_r, ero_mask_nxt;
  logic [MASK_W-1:0] dil_mask_r, dil_mask_nxt;

  always_comb begin
    int ea, eb, ek, dk;
    ea = 0;
    eb = 0;
    ek = 0;
    dk = 0;
    for (int dr = 0; dr < MAX_K; dr++) begin
      for (int dc = 0; dc < MAX_K; dc++) begin
        ea = int'(kr) - 1 - dr;
        eb = int'(kc) - 1 - dc;
        ek = ea * MAX_K + eb;
        dk = dr * MAX_K + dc;
        ero_mask_nxt[dk] = (dr < int'(kr)) && (dc < int'(kc)) && (ek < ELEM_IDX_LIMIT)
                           && strel_mask_r[ek[IDX_W-1:0]];
        dil_mask_nxt[dk] = (dr < int'(kr)) && (dc < int'(kc)) && (dk < ELEM_IDX_LIMIT)
                           && strel_mask_r[dk[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    ero_mask_r <= ero_mask_nxt;
    dil_mask_r <= dil_mask_nxt;
  end

  // ---------------------------------------------------------------- handshake
  logic s1_vld_r, s1_adv, in_acc;
  logic out_vld_r, out_vld_nxt;
  logic s1_emit_r, s1_row_end_r, s1_frame_end_r, s1_pix_r;
  logic [SLOT_W-1:0] s1_slot_r;

  // The window stage moves on when its item needs no output slot or one is free.
  assign s1_adv      = s1_vld_r && (!s1_emit_r || !out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  // ---------------------------------------------------------------- position
  logic [ROW_CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]     col_cnt_r, col_cnt_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 last_col, last_row, emit;

  always_comb begin
    last_col = (NC_W'(col_cnt_r) + NC_W'(1)) >= nc;
    last_row = (IMG_ROWS_W'(row_cnt_r) + IMG_ROWS_W'(1)) >= nr;
    emit     = ((IMG_ROWS_W'(row_cnt_r) + IMG_ROWS_W'(1)) >= IMG_ROWS_W'(kr))
               && ((NC_W'(col_cnt_r) + NC_W'(1)) >= NC_W'(kc));

    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r + COL_W'(1);
    slot_nxt    = slot_r;
    if (last_col) begin
      col_cnt_nxt = '0;
      if (last_row) begin
        row_cnt_nxt = '0;
        slot_nxt    = '0;
      end else begin
        row_cnt_nxt = row_cnt_r + ROW_CNT_W'(1);
        slot_nxt    = (int'(slot_r) == LINES - 1) ? '0 : slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      slot_r    <= '0;
    end else if (in_acc) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      slot_r    <= slot_nxt;
    end
  end

  // ---------------------------------------------------------------- line store
  // One single-bit memory per line slot, all indexed by column. Each accepted
  // item reads every slot (old data, read before write) and writes its own.
  logic [LINES-1:0] s1_line_r;

  for (genvar s = 0; s < LINES; s++) begin : g_line
    logic line_mem [MAX_COLS];

    always_ff @(posedge clk) begin
      if (in_acc) begin
        s1_line_r[s] <= line_mem[col_cnt_r];
        if (int'(slot_r) == s) begin
          line_mem[col_cnt_r] <= in_if.pixel_in;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r       <= in_if.pixel_in;
      s1_slot_r      <= slot_r;
      s1_emit_r      <= emit;
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
    end
  end

  bmf_ctrl_t win_ctrl;
  logic      win_result;

  assign win_ctrl.adv  = s1_adv;
  assign win_ctrl.mode = mode_r;

  bmf_window #(
    .MAX_K (MAX_K)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (win_ctrl),
    .pixel     (s1_pix_r),
    .line_bits (s1_line_r),
    .slot      (s1_slot_r),
    .ero_mask  (ero_mask_r),
    .dil_mask  (dil_mask_r),
    .result    (win_result)
  );

  // ---------------------------------------------------------------- output
  logic out_pix_r, out_row_end_r, out_frame_end_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv && s1_emit_r) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_pix_r       <= win_result;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.pixel_out = out_pix_r;
  assign out_if.row_end   = out_row_end_r;
  assign out_if.frame_end = out_frame_end_r;

  // ---------------------------------------------------------------- checks
  // A frame can only end on the last pixel of a row.
  `BMF_ASSERT_NOW(a_frame_on_row_end, clk, rst_n, out_vld_r && out_frame_end_r, out_row_end_r, "frame_end without row_end")
  // A pending result behind a stalled output must stay in the window stage.
  `BMF_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_vld_r && s1_emit_r && out_vld_r && !out_if.ready, s1_vld_r, "result dropped under stall")
  // The line slot restarts together with the row counter.
  `BMF_ASSERT_NOW(a_slot_row0, clk, rst_n, row_cnt_r == '0, slot_r == '0, "line slot out of step with row counter")

endmodule
